// ===== rtl/cts_pkg.sv =====
package cts_pkg;

	localparam int MAX_TASKS_DEF = 8;
	localparam int MAX_RESULTS   = 8;
	localparam int NRES_W        = $clog2(MAX_RESULTS + 1);

	localparam int CD_W  = 9;
	localparam int PER_W = 8;

	localparam logic [1:0] FUNC_ADD  = 2'd0;
	localparam logic [1:0] FUNC_DEL  = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;

	localparam logic [2:0] ST_ADDED      = 3'd0;
	localparam logic [2:0] ST_FULL       = 3'd1;
	localparam logic [2:0] ST_DELETED    = 3'd2;
	localparam logic [2:0] ST_DEL_UNDEF  = 3'd3;
	localparam logic [2:0] ST_DISPATCHED = 3'd4;
	localparam logic [2:0] ST_NONE_READY = 3'd5;

	typedef enum logic {
		ALU_INC,
		ALU_DEC
	} alu_op_t;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] task_index;
		logic [7:0] start_delay;
		logic [7:0] period;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [2:0] task_id;
		logic       last;
	} rsp_t;

endpackage

// ===== rtl/cts_req_if.sv =====
interface cts_req_if;
	import cts_pkg::*;

	logic valid;
	logic ready;
	req_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/cts_rsp_if.sv =====
interface cts_rsp_if;
	import cts_pkg::*;

	logic valid;
	logic ready;
	rsp_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== rtl/cts_ram.sv =====
module cts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/cts_alu.sv =====
module cts_alu (
	input  cts_pkg::alu_op_t          op,
	input  logic [cts_pkg::CD_W-1:0] operand,
	output logic [cts_pkg::CD_W-1:0] result,
	output logic                      zero
);
	import cts_pkg::*;

	always_comb begin
		unique case (op)
			ALU_INC: result = operand + CD_W'(1);
			ALU_DEC: result = operand - CD_W'(1);
			default: result = operand;
		endcase
		zero = (result == '0);
	end
endmodule

// ===== rtl/cooperative_task_scheduler_core.sv =====
// Cooperative task scheduler core.
// req channel carries one command per transfer: add a task (start delay and
// period), delete a task by slot, or a timer tick. rsp channel returns the
// results; the final result of each command has last set.
// Add and delete put their one result on rsp once the output register is free,
// and req stays low until then.
// A tick walks the slot table through one decrement unit and a single
// countdown/period RAM, one slot per cycle, to update countdowns, then walks
// the slots again to dispatch ready tasks in ascending order (at most eight
// results, or one "none ready" result), then sends the final result. req
// stays low from the tick's transfer until the final result is loaded.
// req is ready only between commands; a new command may be taken while the
// last result still sits in the output register.
// When rsp stalls, the output register holds and the dispatch walk waits.
// Reset clears the valid, pending and free-slot state at once; no clearing
// pass runs, since RAM entries are only used for slots that were added.
module cooperative_task_scheduler_core #(
	parameter int MAX_TASKS = cts_pkg::MAX_TASKS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	cts_req_if.sink   req,
	cts_rsp_if.source rsp
);
	import cts_pkg::*;

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);
	localparam int RAM_W = PER_W + CD_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DISPATCH,
		S_FLUSH
	} state_t;

	state_t                 state_q;
	logic [MAX_TASKS-1:0]   valid_q;
	logic [MAX_TASKS-1:0]   pending_q;
	logic [MAX_TASKS-1:0]   oneshot_q;
	logic [CNT_W-1:0]       next_free_q;
	logic [CNT_W-1:0]       scan_q;
	logic [CNT_W-1:0]       dsp_q;
	logic [NRES_W-1:0]      n_q;
	logic                   vld_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic                   held_vld_q;
	logic [2:0]             held_status_q;
	logic [2:0]             held_id_q;
	logic                   out_valid_q;
	rsp_t                   out_q;

	logic                   acc;
	logic                   out_free;
	logic                   out_load;
	logic                   table_open;
	logic                   del_ok;
	logic [IDX_W-1:0]       del_idx;
	logic                   rd_en;
	logic [IDX_W-1:0]       rd_addr;
	logic [RAM_W-1:0]       rd_data;
	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [RAM_W-1:0]       ram_wdata;
	alu_op_t                alu_op;
	logic [CD_W-1:0]        alu_in;
	logic [CD_W-1:0]        alu_res;
	logic                   alu_zero;
	logic [IDX_W-1:0]       dsp_idx;
	logic                   dsp_done;
	logic                   scan_fire;

	assign req.ready  = (state_q == S_IDLE);
	assign acc        = req.valid && req.ready;
	assign rsp.valid  = out_valid_q;
	assign rsp.data   = out_q;
	assign out_free   = !out_valid_q || rsp.ready;

	assign table_open = (next_free_q != CNT_W'(MAX_TASKS));
	assign del_idx    = req.data.task_index[IDX_W-1:0];
	assign del_ok     = ({1'b0, req.data.task_index} < 9'(MAX_TASKS)) && valid_q[del_idx];

	assign rd_en      = (scan_q != CNT_W'(MAX_TASKS));
	assign rd_addr    = scan_q[IDX_W-1:0];
	assign dsp_idx    = dsp_q[IDX_W-1:0];
	assign dsp_done   = (dsp_q == CNT_W'(MAX_TASKS)) || (n_q == NRES_W'(MAX_RESULTS));
	assign scan_fire  = (state_q == S_SCAN) && vld_s1 && valid_q[idx_s1];

	// Load the output register with a non-final dispatch or with the final result.
	assign out_load   = ((state_q == S_DISPATCH) && !dsp_done && pending_q[dsp_idx] &&
	                     held_vld_q && out_free) ||
	                    ((state_q == S_FLUSH) && out_free);

	// One unit serves both the add path (delay + 1) and the tick decrement.
	always_comb begin
		if (state_q == S_SCAN) begin
			alu_op = ALU_DEC;
			alu_in = rd_data[CD_W-1:0];
		end else begin
			alu_op = ALU_INC;
			alu_in = {1'b0, req.data.start_delay};
		end
	end

	cts_alu u_alu (
		.op      (alu_op),
		.operand (alu_in),
		.result  (alu_res),
		.zero    (alu_zero)
	);

	always_comb begin
		if (state_q == S_SCAN) begin
			ram_we    = scan_fire;
			ram_waddr = idx_s1;
			if (alu_zero) begin
				ram_wdata = {rd_data[RAM_W-1:CD_W], 1'b0, rd_data[RAM_W-1:CD_W]};
			end else begin
				ram_wdata = {rd_data[RAM_W-1:CD_W], alu_res};
			end
		end else begin
			ram_we    = acc && (req.data.func == FUNC_ADD) && table_open;
			ram_waddr = next_free_q[IDX_W-1:0];
			ram_wdata = {req.data.period, alu_res};
		end
	end

	cts_ram #(
		.WIDTH (RAM_W),
		.DEPTH (MAX_TASKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			valid_q       <= '0;
			pending_q     <= '0;
			oneshot_q     <= '0;
			next_free_q   <= '0;
			scan_q        <= '0;
			dsp_q         <= '0;
			n_q           <= '0;
			vld_s1        <= 1'b0;
			idx_s1        <= '0;
			held_vld_q    <= 1'b0;
			held_status_q <= ST_NONE_READY;
			held_id_q     <= '0;
			out_valid_q   <= 1'b0;
			out_q         <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						unique case (req.data.func)
							FUNC_ADD: begin
								if (table_open) begin
									valid_q[next_free_q[IDX_W-1:0]]   <= 1'b1;
									pending_q[next_free_q[IDX_W-1:0]] <= 1'b0;
									oneshot_q[next_free_q[IDX_W-1:0]] <=
										(req.data.period == '0);
									next_free_q   <= next_free_q + CNT_W'(1);
									held_status_q <= ST_ADDED;
									held_id_q     <= 3'(next_free_q[IDX_W-1:0]);
								end else begin
									held_status_q <= ST_FULL;
									held_id_q     <= '0;
								end
								state_q <= S_FLUSH;
							end
							FUNC_DEL: begin
								if (del_ok) begin
									valid_q[del_idx]   <= 1'b0;
									pending_q[del_idx] <= 1'b0;
									held_status_q      <= ST_DELETED;
									held_id_q          <= 3'(del_idx);
								end else begin
									held_status_q <= ST_DEL_UNDEF;
									held_id_q     <= '0;
								end
								state_q <= S_FLUSH;
							end
							FUNC_TICK: begin
								scan_q  <= '0;
								vld_s1  <= 1'b0;
								state_q <= S_SCAN;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_SCAN: begin
					vld_s1 <= rd_en;
					idx_s1 <= rd_addr;
					if (rd_en) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					if (scan_fire && alu_zero) begin
						pending_q[idx_s1] <= 1'b1;
					end
					if (!rd_en && !vld_s1) begin
						dsp_q         <= '0;
						n_q           <= '0;
						held_vld_q    <= 1'b0;
						held_status_q <= ST_NONE_READY;
						held_id_q     <= '0;
						state_q       <= S_DISPATCH;
					end
				end

				S_DISPATCH: begin
					if (dsp_done) begin
						state_q <= S_FLUSH;
					end else if (pending_q[dsp_idx]) begin
						// Hold the newest hit; the one before it goes out with last low.
						if (!held_vld_q || out_free) begin
							if (held_vld_q) begin
								out_q <= '{status: ST_DISPATCHED, task_id: held_id_q,
								           last: 1'b0};
							end
							pending_q[dsp_idx] <= 1'b0;
							if (oneshot_q[dsp_idx]) begin
								valid_q[dsp_idx] <= 1'b0;
							end
							held_vld_q    <= 1'b1;
							held_status_q <= ST_DISPATCHED;
							held_id_q     <= 3'(dsp_idx);
							n_q           <= n_q + NRES_W'(1);
							dsp_q         <= dsp_q + CNT_W'(1);
						end
					end else begin
						dsp_q <= dsp_q + CNT_W'(1);
					end
				end

				S_FLUSH: begin
					if (out_free) begin
						out_q      <= '{status: held_status_q, task_id: held_id_q,
						                last: 1'b1};
						held_vld_q <= 1'b0;
						state_q    <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end
endmodule
